[src/string_escape_decoder_macros.svh]
// Assertion helpers for the string escape decoder.
// Each helper samples on clk and is disabled while rst_n is low.
`ifndef STRING_ESCAPE_DECODER_MACROS_SVH
`define STRING_ESCAPE_DECODER_MACROS_SVH
`ifndef SYNTH
// Condition holds in the same cycle as its trigger
`define SED_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sed: same-cycle check failed");
// Condition holds in the cycle after its trigger
`define SED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sed: next-cycle check failed");
`else
`define SED_ASSERT_IMPL(label, ante, cons)
`define SED_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[src/sed_pkg.sv]
package sed_pkg;

    // Status codes carried with each result
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_UNKNOWN    = 3'd1;
    localparam logic [2:0] ST_INC_UNI    = 3'd2;
    localparam logic [2:0] ST_INC_HEX    = 3'd3;
    localparam logic [2:0] ST_BAD_DIGIT  = 3'd4;

    // Results one input byte can cause at most
    localparam int MAX_RES = 3;

    // Depth of the queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] status;
        logic       last_of_run;
        logic       string_done;
    } out_item_t;

    // All results of one input byte, count is 1 to 3
    typedef struct packed {
        logic [1:0]                count;
        out_item_t [MAX_RES-1:0]   res;
    } sed_bundle_t;

    function automatic out_item_t make_result(logic [7:0] b, logic valid, logic [2:0] st);
        out_item_t r;
        r.out_byte    = b;
        r.byte_valid  = valid;
        r.status      = st;
        r.last_of_run = 1'b0;
        r.string_done = 1'b0;
        return r;
    endfunction

    // Returns {ok, value} for an ASCII hex digit
    function automatic logic [4:0] hex_digit(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

[src/sed_front.sv]
module sed_front
    import sed_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  in_item_t    in_item,
    output logic        bundle_wr,
    output sed_bundle_t bundle
);

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_ESC  = 2'd1;
    localparam logic [1:0] MODE_UNI  = 2'd2;
    localparam logic [1:0] MODE_HEX  = 2'd3;

    logic [1:0]  mode_reg, mode_next;
    logic [2:0]  digits_reg, digits_next;
    logic [15:0] acc_reg, acc_next;

    logic [1:0]  cnt;
    logic [4:0]  hex;
    logic [15:0] acc_shift;
    logic [7:0]  b;

    // Decode one byte into its results and the next escape state
    always_comb
    begin
        b           = in_item.in_byte;
        hex         = hex_digit(b);
        acc_shift   = {acc_reg[11:0], hex[3:0]};
        bundle      = '0;
        cnt         = 2'd0;
        mode_next   = mode_reg;
        digits_next = digits_reg;
        acc_next    = acc_reg;

        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (b == 8'h5C)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    bundle.res[cnt] = make_result(b, 1'b1, ST_OK);
                    cnt = cnt + 2'd1;
                end
            end
            MODE_ESC:
            begin
                mode_next = MODE_IDLE;
                unique case (b)
                    8'h75:
                    begin
                        mode_next   = MODE_UNI;
                        digits_next = 3'd4;
                        acc_next    = 16'd0;
                    end
                    8'h78:
                    begin
                        mode_next   = MODE_HEX;
                        digits_next = 3'd2;
                        acc_next    = 16'd0;
                    end
                    8'h5C, 8'h27, 8'h22:
                    begin
                        bundle.res[cnt] = make_result(b, 1'b1, ST_OK);
                        cnt = cnt + 2'd1;
                    end
                    8'h62:
                    begin
                        bundle.res[cnt] = make_result(8'h08, 1'b1, ST_OK);
                        cnt = cnt + 2'd1;
                    end
                    8'h66:
                    begin
                        bundle.res[cnt] = make_result(8'h0C, 1'b1, ST_OK);
                        cnt = cnt + 2'd1;
                    end
                    8'h6E:
                    begin
                        bundle.res[cnt] = make_result(8'h0A, 1'b1, ST_OK);
                        cnt = cnt + 2'd1;
                    end
                    8'h72:
                    begin
                        bundle.res[cnt] = make_result(8'h0D, 1'b1, ST_OK);
                        cnt = cnt + 2'd1;
                    end
                    8'h74:
                    begin
                        bundle.res[cnt] = make_result(8'h09, 1'b1, ST_OK);
                        cnt = cnt + 2'd1;
                    end
                    8'h76:
                    begin
                        bundle.res[cnt] = make_result(8'h0B, 1'b1, ST_OK);
                        cnt = cnt + 2'd1;
                    end
                    default:
                    begin
                        bundle.res[cnt] = make_result(b, 1'b1, ST_UNKNOWN);
                        cnt = cnt + 2'd1;
                    end
                endcase
            end
            MODE_UNI, MODE_HEX:
            begin
                if (!hex[4])
                begin
                    // Drop the escape on a bad digit
                    bundle.res[cnt] = make_result(8'h00, 1'b0, ST_BAD_DIGIT);
                    cnt = cnt + 2'd1;
                    mode_next   = MODE_IDLE;
                    digits_next = 3'd0;
                    acc_next    = 16'd0;
                end
                else if (digits_reg <= 3'd1)
                begin
                    if (mode_reg == MODE_HEX)
                    begin
                        bundle.res[cnt] = make_result(acc_shift[7:0], 1'b1, ST_OK);
                        cnt = cnt + 2'd1;
                    end
                    else if (acc_shift < 16'h0080)
                    begin
                        bundle.res[cnt] = make_result(acc_shift[7:0], 1'b1, ST_OK);
                        cnt = cnt + 2'd1;
                    end
                    else if (acc_shift < 16'h0800)
                    begin
                        bundle.res[0] = make_result(8'hC0 | {3'b000, acc_shift[10:6]},
                                                    1'b1, ST_OK);
                        bundle.res[1] = make_result(8'h80 | {2'b00, acc_shift[5:0]},
                                                    1'b1, ST_OK);
                        cnt = 2'd2;
                    end
                    else
                    begin
                        bundle.res[0] = make_result(8'hE0 | {4'h0, acc_shift[15:12]},
                                                    1'b1, ST_OK);
                        bundle.res[1] = make_result(8'h80 | {2'b00, acc_shift[11:6]},
                                                    1'b1, ST_OK);
                        bundle.res[2] = make_result(8'h80 | {2'b00, acc_shift[5:0]},
                                                    1'b1, ST_OK);
                        cnt = 2'd3;
                    end
                    mode_next   = MODE_IDLE;
                    digits_next = 3'd0;
                    acc_next    = 16'd0;
                end
                else
                begin
                    digits_next = digits_reg - 3'd1;
                    acc_next    = acc_shift;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        // Flag an escape cut off by the end and return to idle
        if (in_item.end_of_string)
        begin
            if (mode_next == MODE_UNI)
            begin
                bundle.res[cnt] = make_result(8'h00, 1'b0, ST_INC_UNI);
                cnt = cnt + 2'd1;
            end
            else if (mode_next == MODE_HEX)
            begin
                bundle.res[cnt] = make_result(8'h00, 1'b0, ST_INC_HEX);
                cnt = cnt + 2'd1;
            end
            else if (mode_next == MODE_ESC)
            begin
                bundle.res[cnt] = make_result(8'h00, 1'b0, ST_UNKNOWN);
                cnt = cnt + 2'd1;
            end
            mode_next   = MODE_IDLE;
            digits_next = 3'd0;
            acc_next    = 16'd0;
        end

        // Mark the final result of this item
        if (cnt != 2'd0)
        begin
            bundle.res[cnt - 2'd1].last_of_run = 1'b1;
            bundle.res[cnt - 2'd1].string_done = in_item.end_of_string;
        end
        bundle.count = cnt;
    end

    assign bundle_wr = accept && (cnt != 2'd0);

    // Advance the escape state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            digits_reg <= 3'd0;
            acc_reg    <= 16'd0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            digits_reg <= digits_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

[src/sed_queue.sv]
module sed_queue
    import sed_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr,
    input  sed_bundle_t wr_data,
    output logic        full,
    input  logic        rd,
    output sed_bundle_t rd_data,
    output logic        nonempty
);

    sed_bundle_t       slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign nonempty = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];

    // Store bundles
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[src/sed_back.sv]
module sed_back
    import sed_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  sed_bundle_t head,
    output logic        head_rd,
    output logic        empty,
    input  logic        pop,
    output out_item_t   out_item
);

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    out_item_t  out_reg;
    logic       load;
    logic       at_last;

    assign load    = head_valid && (!out_valid_reg || pop);
    assign at_last = (idx_reg == head.count - 2'd1);
    assign head_rd = load && at_last;

    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    // Hold the output item until taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= head.res[idx_reg];
        end
    end

    // Step through the head bundle one result a cycle while the output is empty or popped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= at_last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[src/string_escape_decoder.sv]
// Channel  | Handshake   | Payload     | Accepted when
// ---------+-------------+-------------+----------------------
// input    | push / full | in_item_t   | push && !full
// result   | empty / pop | out_item_t  | pop && !empty
//
// An item is accepted every cycle while the queue between decoder and
// serializer has room; the first result passes through the queue and then
// the output register. The serializer sends one result per cycle while
// results are popped; bursts are absorbed by a 4-deep queue of bundles.
// Reset clears the escape state, the queue and the output valid flag.
// A stalled result side fills the queue, then raises full.
`include "string_escape_decoder_macros.svh"

module string_escape_decoder
    import sed_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    logic        accept;
    logic        bundle_wr;
    sed_bundle_t bundle;
    logic        head_rd;
    logic        head_valid;
    sed_bundle_t head;

    assign accept = push && !full;

    // Classify bytes and build result bundles
    sed_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_item   (in_item),
        .bundle_wr (bundle_wr),
        .bundle    (bundle)
    );

    // Decouple decoder from serializer
    sed_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (bundle_wr),
        .wr_data  (bundle),
        .full     (full),
        .rd       (head_rd),
        .rd_data  (head),
        .nonempty (head_valid)
    );

    // Emit one result per cycle while results are popped
    sed_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_rd    (head_rd),
        .empty      (empty),
        .pop        (pop),
        .out_item   (out_item)
    );

    `SED_ASSERT_IMPL(a_done_is_last, !empty && out_item.string_done, out_item.last_of_run)
    `SED_ASSERT_IMPL(a_invalid_zero, !empty && !out_item.byte_valid, out_item.out_byte == 8'h00)
    `SED_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty)
    `SED_ASSERT_NEXT(a_hold_data, !empty && !pop, $stable(out_item))

endmodule
